/* rtl/ple_pkg.sv */
// shared types, constants and codes for the positional list engine
package ple_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 32;
    localparam int HALF        = MAX_RESULTS / 2;

    localparam int VAL_W  = 32;
    localparam int ACT_W  = 4;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int OIDX_W = 5;
    localparam int OCC_W  = 5;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 4'd0,
        ACT_INS_BACK  = 4'd1,
        ACT_INS_AT    = 4'd2,
        ACT_SEARCH    = 4'd3,
        ACT_COUNT     = 4'd4,
        ACT_DEL_FRONT = 4'd5,
        ACT_DEL_BACK  = 4'd6,
        ACT_DEL_AT    = 4'd7,
        ACT_DUMP      = 4'd8
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_BADPOS = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_MISS   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DUMP_FWD,
        S_DUMP_REV
    } ple_state_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] data;
    } cell_op_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } search_t;

endpackage

/* rtl/ple_if.sv */
// request and result channel interfaces of the positional list engine
interface ple_req_if
    import ple_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, action, value, position, input ready);
    modport sink   (input valid, action, value, position, output ready);
endinterface

interface ple_rsp_if
    import ple_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] item_value;
    logic [OIDX_W-1:0]       item_index;
    logic [OCC_W-1:0]        occupancy_out;
    logic                    reverse_pass;
    logic                    last;

    modport source (output valid, status, item_value, item_index, occupancy_out,
                    reverse_pass, last, input ready);
    modport sink   (input valid, status, item_value, item_index, occupancy_out,
                    reverse_pass, last, output ready);
endinterface

/* rtl/ple_cell.sv */
// one storage cell of the list row: shifts with its neighbors and compares a key
module ple_cell
    import ple_pkg::*;
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [CNT_W-1:0] occ,
    input  logic [VAL_W-1:0] left_val,
    input  logic [VAL_W-1:0] right_val,
    output logic [VAL_W-1:0] val,
    output logic             hit
);

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (op.ins && (cell_idx == op.pos))
        begin
            val_next = op.data;
        end
        else if (op.ins && (cell_idx > op.pos))
        begin
            val_next = left_val;
        end
        else if (op.del && (cell_idx >= op.pos))
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    // only occupied cells take part in a search
    assign hit = (val_reg == op.data) && (CNT_W'(cell_idx) < occ);

endmodule

/* rtl/ple_chain.sv */
// row of list cells with first-match encoder and a single read port
module ple_chain
    import ple_pkg::*;
(
    input  logic             clk,
    input  cell_op_t         op,
    input  logic [CNT_W-1:0] occ,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [VAL_W-1:0] rd_data,
    output search_t          srch
);

    logic [VAL_W-1:0]    vals [CAPACITY];
    logic [CAPACITY-1:0] hits;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = vals[i];
        end
        else
        begin : g_mid_r
            assign right_val = vals[i+1];
        end

        ple_cell u_cell (
            .clk       (clk),
            .op        (op),
            .cell_idx  (IDX_W'(i)),
            .occ       (occ),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (vals[i]),
            .hit       (hits[i])
        );
    end

    assign rd_data = vals[rd_idx];

    // lowest matching cell wins
    always_comb
    begin
        srch.hit = |hits;
        srch.idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                srch.idx = IDX_W'(i);
            end
        end
    end

endmodule

/* rtl/positional_list_engine.sv */
// top level of the positional list engine: request decode, dump sequencer, result register
//
// Keeps an ordered list of up to CAPACITY signed 32-bit values in a row of cells that shift
// right on insert and left on delete, and compare the key in parallel on search. Every request
// except a dump of a non-empty list gives one result with last set; while no dump runs, a new
// request is taken in any cycle in which the result register is empty or being drained, so such
// requests run one per cycle against a ready sink. A dump of n stored values (n capped at
// MAX_RESULTS/2) holds off requests: it enters the forward state, then gives one result per
// cycle against a ready sink through the single read port of the cell row, forward from the
// head, then backward from the tail, the final one with last; results wait in one output register.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req_ch,
    ple_rsp_if.source rsp_ch
);

    ple_state_t state_reg, state_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [STAT_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]  item_reg, item_next;
    logic [OIDX_W-1:0] index_reg, index_next;
    logic [OCC_W-1:0]  occ_out_reg, occ_out_next;
    logic              rev_reg, rev_next;
    logic              last_reg, last_next;

    cell_op_t         op;
    logic [IDX_W-1:0] rd_idx;
    logic [VAL_W-1:0] rd_data;
    search_t          srch;

    logic             slot_free;
    logic             accept;
    action_t          act;
    logic [CMP_W-1:0] occ_ext;
    logic [CMP_W-1:0] ipos;
    logic [CMP_W-1:0] dpos;
    logic [CNT_W-1:0] dump_n;

    ple_chain u_chain (
        .clk     (clk),
        .op      (op),
        .occ     (occ_reg),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .srch    (srch)
    );

    assign slot_free    = !out_valid_reg || rsp_ch.ready;
    assign req_ch.ready = (state_reg == S_IDLE) && slot_free;
    assign accept       = req_ch.valid && req_ch.ready;
    assign act          = action_t'(req_ch.action);
    assign occ_ext      = CMP_W'(occ_reg);

    always_comb
    begin
        ipos = CMP_W'(req_ch.position);
        case (act)
            ACT_INS_FRONT: ipos = '0;
            ACT_INS_BACK:  ipos = occ_ext;
            default:       ipos = CMP_W'(req_ch.position);
        endcase
    end

    always_comb
    begin
        dpos = CMP_W'(req_ch.position);
        case (act)
            ACT_DEL_FRONT: dpos = '0;
            ACT_DEL_BACK:  dpos = occ_ext - CMP_W'(1);
            default:       dpos = CMP_W'(req_ch.position);
        endcase
    end

    always_comb
    begin
        if (int'(occ_reg) < HALF)
        begin
            dump_n = occ_reg;
        end
        else
        begin
            dump_n = CNT_W'(HALF);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp_ch.ready;
        status_next    = status_reg;
        item_next      = item_reg;
        index_next     = index_reg;
        occ_out_next   = occ_out_reg;
        rev_next       = rev_reg;
        last_next      = last_reg;
        op.ins         = 1'b0;
        op.del         = 1'b0;
        op.pos         = '0;
        op.data        = req_ch.value;
        rd_idx         = IDX_W'(dpos);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    item_next      = '0;
                    index_next     = '0;
                    rev_next       = 1'b0;
                    last_next      = 1'b1;
                    case (act)
                        ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT:
                        begin
                            if (ipos > occ_ext)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else if (int'(occ_reg) >= CAPACITY)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                op.ins   = 1'b1;
                                op.pos   = IDX_W'(ipos);
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (srch.hit)
                            begin
                                item_next  = req_ch.value;
                                index_next = OIDX_W'(srch.idx);
                            end
                            else
                            begin
                                status_next = STAT_MISS;
                            end
                        end
                        ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT:
                        begin
                            if ((occ_reg == '0) && (act != ACT_DEL_AT))
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (dpos >= occ_ext)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                op.del    = 1'b1;
                                op.pos    = IDX_W'(dpos);
                                item_next = rd_data;
                                occ_next  = occ_reg - CNT_W'(1);
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                // results come from the sequencer states
                                out_valid_next = out_valid_reg && !rsp_ch.ready;
                                status_next    = status_reg;
                                item_next      = item_reg;
                                index_next     = index_reg;
                                rev_next       = rev_reg;
                                last_next      = last_reg;
                                cnt_next       = '0;
                                state_next     = S_DUMP_FWD;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                    occ_out_next = OCC_W'(occ_next);
                end
            end

            S_DUMP_FWD:
            begin
                rd_idx = IDX_W'(cnt_reg);
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    item_next      = rd_data;
                    index_next     = OIDX_W'(rd_idx);
                    occ_out_next   = OCC_W'(occ_reg);
                    rev_next       = 1'b0;
                    last_next      = 1'b0;
                    if (cnt_reg == dump_n - CNT_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_DUMP_REV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end

            S_DUMP_REV:
            begin
                // walk back from the tail
                rd_idx = IDX_W'(occ_reg - CNT_W'(1) - cnt_reg);
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    item_next      = rd_data;
                    index_next     = OIDX_W'(rd_idx);
                    occ_out_next   = OCC_W'(occ_reg);
                    rev_next       = 1'b1;
                    last_next      = (cnt_reg == dump_n - CNT_W'(1));
                    if (cnt_reg == dump_n - CNT_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        item_reg    <= item_next;
        index_reg   <= index_next;
        occ_out_reg <= occ_out_next;
        rev_reg     <= rev_next;
        last_reg    <= last_next;
    end

    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.status        = status_reg;
    assign rsp_ch.item_value    = item_reg;
    assign rsp_ch.item_index    = index_reg;
    assign rsp_ch.occupancy_out = occ_out_reg;
    assign rsp_ch.reverse_pass  = rev_reg;
    assign rsp_ch.last          = last_reg;

endmodule
